@@ rtl/core/bdq_pkg.sv @@
// Shared types for the bounded double-ended queue: action codes, controller
// states, datapath command and status bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  // Action codes carried by each input transaction
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_LIST       = 3'd4
  } action_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_POP_WAIT = 2'd1,
    ST_LIST     = 2'd2
  } state_t;

  // Which slot the storage port addresses this cycle
  typedef enum logic [2:0] {
    ADDR_FRONT_DEC  = 3'd0,  // slot ahead of the front element
    ADDR_BACK_FREE  = 3'd1,  // first free slot behind the back element
    ADDR_FRONT      = 3'd2,  // front element
    ADDR_BACK       = 3'd3,  // back element
    ADDR_LIST       = 3'd4   // element at the running list offset
  } addr_sel_t;

  // Pointer and count update
  typedef enum logic [2:0] {
    PTR_NONE       = 3'd0,
    PTR_PUSH_FRONT = 3'd1,
    PTR_PUSH_BACK  = 3'd2,
    PTR_POP_FRONT  = 3'd3,
    PTR_POP_BACK   = 3'd4
  } ptr_op_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic      wr_en;
    logic      rd_en;
    addr_sel_t addr_sel;
    ptr_op_t   ptr_op;
    logic      list_load;
    logic      list_step;
    logic      emit;
    logic      emit_ok;
    logic      emit_ram_data;
    logic      emit_last;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic list_done;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/bdq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bdq_datapath.sv @@
// Datapath of the double-ended queue: slot storage, front pointer, element
// count, list offset and result registers. Uses bdq_pkg and bdq_ram.
`timescale 1ns / 1ps
`default_nettype none

module bdq_datapath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = $clog2(DEPTH),
  parameter int CNT_W      = $clog2(DEPTH + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bdq_pkg::ctrl_cmd_t           cmd,
  output bdq_pkg::dp_status_t               status,
  input  wire logic signed [DATA_WIDTH-1:0] data_in,
  output logic                              done,
  output logic                              ok,
  output logic signed [DATA_WIDTH-1:0]      data_out,
  output logic [CNT_W-1:0]                  element_count,
  output logic                              is_empty,
  output logic                              last
);

  logic [IDX_W-1:0]      front;
  logic [IDX_W-1:0]      front_next;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W-1:0]      list_off;
  logic [CNT_W-1:0]      offset;
  logic [IDX_W-1:0]      addr;
  logic [IDX_W-1:0]      front_inc;
  logic [DATA_WIDTH-1:0] rdata;

  // Add an offset below DEPTH to an index and wrap around the buffer
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Select the slot offset from the front
  always_comb begin
    unique case (cmd.addr_sel)
      bdq_pkg::ADDR_FRONT_DEC: offset = CNT_W'(DEPTH - 1);
      bdq_pkg::ADDR_BACK_FREE: offset = count;
      bdq_pkg::ADDR_FRONT:     offset = '0;
      bdq_pkg::ADDR_BACK:      offset = count - CNT_W'(1);
      bdq_pkg::ADDR_LIST:      offset = list_off;
      default:                 offset = '0;
    endcase
  end

  assign addr      = wrap_add(front, offset);
  assign front_inc = wrap_add(front, CNT_W'(1));

  // Compute pointer and count updates
  always_comb begin
    front_next = front;
    count_next = count;
    unique case (cmd.ptr_op)
      bdq_pkg::PTR_NONE: begin
      end
      bdq_pkg::PTR_PUSH_FRONT: begin
        front_next = addr;
        count_next = count + CNT_W'(1);
      end
      bdq_pkg::PTR_PUSH_BACK: begin
        count_next = count + CNT_W'(1);
      end
      bdq_pkg::PTR_POP_FRONT: begin
        front_next = front_inc;
        count_next = count - CNT_W'(1);
      end
      bdq_pkg::PTR_POP_BACK: begin
        count_next = count - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Hold pointer, count and list offset
  always_ff @(posedge clk) begin
    if (rst) begin
      front    <= '0;
      count    <= '0;
      list_off <= '0;
    end else begin
      front <= front_next;
      count <= count_next;
      if (cmd.list_load) begin
        list_off <= CNT_W'(1);
      end else if (cmd.list_step) begin
        list_off <= list_off + CNT_W'(1);
      end
    end
  end

  // Slot storage
  bdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (addr),
    .wdata (data_in),
    .re    (cmd.rd_en),
    .raddr (addr),
    .rdata (rdata)
  );

  // Register one result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      ok       <= cmd.emit_ok;
      data_out <= cmd.emit_ram_data ? rdata : '0;
    end
  end

  // The last mark rides with the result payload
  logic last_q;
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      last_q <= cmd.emit_last;
    end
  end

  assign last             = last_q;
  assign element_count    = count;
  assign is_empty         = (count == '0);
  assign status.full      = (count == CNT_W'(DEPTH));
  assign status.empty     = (count == '0);
  assign status.list_done = (list_off == count);

endmodule

`default_nettype wire

@@ rtl/core/bdq_controller.sv @@
// Controller state machine of the double-ended queue: decodes each action
// and sequences storage reads and result emission. Uses bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_controller (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [2:0]          action,
  input  wire bdq_pkg::dp_status_t status,
  output logic                     busy,
  output bdq_pkg::ctrl_cmd_t       cmd
);

  bdq_pkg::state_t state;
  bdq_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != bdq_pkg::ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next        = state;
    cmd.wr_en         = 1'b0;
    cmd.rd_en         = 1'b0;
    cmd.addr_sel      = bdq_pkg::ADDR_FRONT;
    cmd.ptr_op        = bdq_pkg::PTR_NONE;
    cmd.list_load     = 1'b0;
    cmd.list_step     = 1'b0;
    cmd.emit          = 1'b0;
    cmd.emit_ok       = 1'b0;
    cmd.emit_ram_data = 1'b0;
    cmd.emit_last     = 1'b1;
    unique case (state)
      bdq_pkg::ST_IDLE: begin
        if (start) begin
          unique case (bdq_pkg::action_t'(action))
            bdq_pkg::ACT_PUSH_FRONT: begin
              cmd.emit    = 1'b1;
              cmd.emit_ok = !status.full;
              if (!status.full) begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = bdq_pkg::ADDR_FRONT_DEC;
                cmd.ptr_op   = bdq_pkg::PTR_PUSH_FRONT;
              end
            end
            bdq_pkg::ACT_PUSH_BACK: begin
              cmd.emit    = 1'b1;
              cmd.emit_ok = !status.full;
              if (!status.full) begin
                cmd.wr_en    = 1'b1;
                cmd.addr_sel = bdq_pkg::ADDR_BACK_FREE;
                cmd.ptr_op   = bdq_pkg::PTR_PUSH_BACK;
              end
            end
            bdq_pkg::ACT_POP_FRONT: begin
              if (status.empty) begin
                cmd.emit = 1'b1;
              end else begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = bdq_pkg::ADDR_FRONT;
                cmd.ptr_op   = bdq_pkg::PTR_POP_FRONT;
                state_next   = bdq_pkg::ST_POP_WAIT;
              end
            end
            bdq_pkg::ACT_POP_BACK: begin
              if (status.empty) begin
                cmd.emit = 1'b1;
              end else begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = bdq_pkg::ADDR_BACK;
                cmd.ptr_op   = bdq_pkg::PTR_POP_BACK;
                state_next   = bdq_pkg::ST_POP_WAIT;
              end
            end
            bdq_pkg::ACT_LIST: begin
              if (status.empty) begin
                cmd.emit    = 1'b1;
                cmd.emit_ok = 1'b1;
              end else begin
                cmd.rd_en     = 1'b1;
                cmd.addr_sel  = bdq_pkg::ADDR_FRONT;
                cmd.list_load = 1'b1;
                state_next    = bdq_pkg::ST_LIST;
              end
            end
            default: begin
              // unused action code: report failure, change nothing
              cmd.emit = 1'b1;
            end
          endcase
        end
      end
      bdq_pkg::ST_POP_WAIT: begin
        // read data is back: emit the popped value
        cmd.emit          = 1'b1;
        cmd.emit_ok       = 1'b1;
        cmd.emit_ram_data = 1'b1;
        state_next        = bdq_pkg::ST_IDLE;
      end
      bdq_pkg::ST_LIST: begin
        // emit the element read last cycle; unless the list is done, fetch the next one
        cmd.emit          = 1'b1;
        cmd.emit_ok       = 1'b1;
        cmd.emit_ram_data = 1'b1;
        cmd.emit_last     = status.list_done;
        if (status.list_done) begin
          state_next = bdq_pkg::ST_IDLE;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.addr_sel  = bdq_pkg::ADDR_LIST;
          cmd.list_step = 1'b1;
        end
      end
      default: begin
        state_next = bdq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/bounded_double_ended_queue.sv @@
// Top level of the bounded double-ended queue: controller plus datapath.
// Uses bdq_pkg, bdq_controller, bdq_datapath (which holds bdq_ram).
//
// A transaction is accepted when start is high and busy is low. Each result
// appears for one cycle with done high and cannot be held off. Pushes,
// failed actions, listing an empty queue and unused action codes show their
// result in the next cycle, while a new transaction may already be
// accepted. A successful pop reads the slot memory, whose read data is
// registered, and emits the value from the pop wait state. A list of n
// elements gives n back-to-back results, front first, the final one with
// last high; the memory read port streams one element per cycle. Count and
// empty flag reflect the state after the action. No clearing pass follows
// reset.
`timescale 1ns / 1ps
`default_nettype none

module bounded_double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [2:0]                   action,
  input  wire logic signed [DATA_WIDTH-1:0] data_in,
  output logic                              done,
  output logic                              ok,
  output logic signed [DATA_WIDTH-1:0]      data_out,
  output logic [$clog2(DEPTH+1)-1:0]        element_count,
  output logic                              is_empty,
  output logic                              last
);

  bdq_pkg::ctrl_cmd_t  cmd;
  bdq_pkg::dp_status_t status;

  bdq_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  bdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .data_in       (data_in),
    .done          (done),
    .ok            (ok),
    .data_out      (data_out),
    .element_count (element_count),
    .is_empty      (is_empty),
    .last          (last)
  );

  // A non-final list result is always followed by another result
  assert property (@(posedge clk) disable iff (rst)
    done && ok && !last |=> done)
    else $error("list stream broke before its last element");

  // The count never exceeds the capacity
  assert property (@(posedge clk) disable iff (rst)
    element_count <= ($clog2(DEPTH+1))'(DEPTH))
    else $error("element count beyond capacity");

  // Popping an empty queue fails in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && is_empty &&
    (action == bdq_pkg::ACT_POP_FRONT || action == bdq_pkg::ACT_POP_BACK)
    |=> done && !ok && last)
    else $error("pop on empty queue did not fail at once");

  // A multi-cycle action never starts with a result already due
  assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> !done)
    else $error("result emitted on entry to a multi-cycle action");

endmodule

`default_nettype wire
